// ----- rtl/single_half_float_convert_defines.svh -----
// assertion macros for the converter rtl
`ifndef SINGLE_HALF_FLOAT_CONVERT_DEFINES_SVH
`define SINGLE_HALF_FLOAT_CONVERT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SHFC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge, reset included
`define SHFC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/shfc_pkg.sv -----
// ----------------------------------------------------------------------------
// shfc_pkg
// shared types and constants for the single/half float converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shfc_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef enum logic {
        KIND_S2H = 1'b0,
        KIND_H2S = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
    } t_item;

    localparam logic [15:0] HALF_INF  = 16'h7C00;
    localparam logic [15:0] HALF_QNAN = 16'h7E00;
    localparam logic [31:0] SGL_INF   = 32'h7F80_0000;
    localparam logic [31:0] SGL_QUIET = 32'h0040_0000;

endpackage

// ----- rtl/shfc_s2h.sv -----
// ----------------------------------------------------------------------------
// shfc_s2h
// single precision to half precision, combinational
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shfc_s2h (
    input  logic [31:0] i_value,
    output logic [15:0] o_half
);
    import shfc_pkg::*;

    logic        sgn;
    logic [7:0]  be;
    logic [22:0] man;
    logic [23:0] man_rnd;
    logic [5:0]  eb;
    logic [3:0]  sh;
    logic [23:0] msub;
    logic [24:0] msum;
    logic [14:0] mag;

    always_comb begin
        sgn     = i_value[31];
        be      = i_value[30:23];
        man     = i_value[22:0];
        man_rnd = {1'b0, man} + 24'h1000;
        // rebias 127 -> 15, plus carry from rounding
        eb      = 6'(be - 8'd112) + {5'd0, man_rnd[23]};
        sh      = 4'(8'd113 - be);
        msub    = {1'b1, man} >> sh;
        msum    = {1'b0, msub} + 25'h1000;
        mag     = '0;
        if (be > 8'd142) begin
            mag = (be == 8'hFF && man != '0) ? HALF_QNAN[14:0] : HALF_INF[14:0];
        end else if (be > 8'd113) begin
            if (eb >= 6'd31) begin
                mag = HALF_INF[14:0];
            end else begin
                mag = {eb[4:0], (man_rnd[23] ? 10'd0 : man_rnd[22:13])};
            end
        end else if (be >= 8'd102) begin
            // rounding carry may reach the exponent field
            mag = {3'd0, msum[24:13]};
        end
        o_half = {sgn, mag};
    end

endmodule

// ----- rtl/shfc_h2s.sv -----
// ----------------------------------------------------------------------------
// shfc_h2s
// half precision to single precision, combinational
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shfc_h2s (
    input  logic [15:0] i_half,
    output logic [31:0] o_single
);
    import shfc_pkg::*;

    logic [4:0] e;
    logic [9:0] man;
    logic [3:0] lz;
    logic [9:0] norm;

    always_comb begin
        e   = i_half[14:10];
        man = i_half[9:0];
        // leading zero count for subnormal normalization
        lz  = 4'd10;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) lz = 4'(9 - i);
        end
        norm = 10'(man << (lz + 4'd1));
        o_single = {i_half[15], 31'd0};
        if (e == 5'h1F) begin
            o_single = o_single | SGL_INF;
            if (man != '0) o_single = o_single | {9'd0, man, 13'd0} | SGL_QUIET;
        end else if (e == 5'd0) begin
            if (man != '0) o_single[30:0] = {8'(8'd113 - 8'(lz) - 8'd1), norm, 13'd0};
        end else begin
            o_single[30:0] = {8'({3'd0, e} + 8'd112), man, 13'd0};
        end
    end

endmodule

// ----- rtl/single_half_float_convert.sv -----
// ----------------------------------------------------------------------------
// single_half_float_convert
// ieee single <-> half bit pattern converter with stream handshakes
// ----------------------------------------------------------------------------
// usage:
//   slave channel: s_axis_tdata = value, s_axis_tuser = kind
//     (0 single to half, 1 half to single, half input in tdata[15:0])
//   master channel: m_axis_tdata = converted (half result in low 16 bits)
//   pipeline: input register, combinational converter, result register
//   throughput: one transaction per cycle while the receiver takes results;
//     the result stage advances whenever the result slot frees up, and the
//     input stage advances when it is empty or the result stage advances
//   stall: when m_axis_tready is low the pipeline holds and s_axis_tready
//     drops only when both stages are full and the receiver is stalled
//   reset: i_rst_n synchronous active low empties both stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "single_half_float_convert_defines.svh"

module single_half_float_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] converted
);
    import shfc_pkg::*;

    logic        r_in_vld, r_out_vld;
    t_item       r_in;
    logic [31:0] r_out;
    logic [15:0] half_res;
    logic [31:0] sgl_res;
    logic        out_adv, in_adv;

    // input stage converter
    shfc_s2h u_s2h (.i_value(r_in.value), .o_half(half_res));
    shfc_h2s u_h2s (.i_half(r_in.value[15:0]), .o_single(sgl_res));

    // result slot frees when empty or being taken
    assign out_adv       = !r_out_vld || m_axis_tready;
    assign in_adv        = !r_in_vld || out_adv;
    assign s_axis_tready = in_adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_adv) r_in_vld <= s_axis_tvalid;
            if (out_adv) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) r_in <= '{kind: t_kind'(s_axis_tuser), value: s_axis_tdata};
        if (out_adv && r_in_vld)
            r_out <= (r_in.kind == KIND_H2S) ? sgl_res : {16'd0, half_res};
    end

    `SHFC_ASSERT(a_hold_out, i_clk, i_rst_n, r_out_vld && !m_axis_tready |=> r_out_vld && $stable(r_out), "result lost under stall")
    `SHFC_ASSERT(a_ready, i_clk, i_rst_n, !s_axis_tready |-> r_in_vld && r_out_vld, "ready low with room")
    `SHFC_ASSERT(a_half_upper, i_clk, i_rst_n, r_out_vld && $past(out_adv && r_in_vld && r_in.kind == KIND_S2H) |-> r_out[31:16] == 16'd0, "half result upper bits set")

endmodule

// ----- verif/tb_single_half_float_convert.sv -----
// ----------------------------------------------------------------------------
// tb_single_half_float_convert
// stream testbench for the single/half float converter: directed corner
// values, then random bit patterns under varying sender/receiver idling,
// every result checked in order against a bit-level conversion predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_single_half_float_convert;

    import shfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic        s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] converted

    // expected converted patterns, oldest first
    logic [31:0] converted_q[$];
    int          error_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          timed_out;

    single_half_float_convert u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // single to half: round half up on bit 12, overflow to infinity
    function automatic logic [31:0] single_to_half(logic [31:0] v);
        logic [7:0]  bexp;
        logic [23:0] frac;
        logic [4:0]  hexp;
        logic [24:0] mag;
        logic [15:0] res;
        int          uexp;
        bexp = v[30:23];
        frac = {1'b0, v[22:0]};
        uexp = int'(bexp) - 127;
        res  = {v[31], 15'd0};
        if (uexp > 15) begin
            // nan becomes the quiet half nan, everything else infinity
            res[14:0] = (bexp == 8'hFF && frac != 0) ? HALF_QNAN[14:0] : HALF_INF[14:0];
        end else if (uexp > -14) begin
            frac = frac + 24'h1000;
            if (frac[23]) begin
                // mantissa rounded up into the exponent
                frac = '0;
                uexp = uexp + 1;
            end
            if (uexp + 15 >= 31) res[14:0] = HALF_INF[14:0];
            else begin
                hexp = 5'(uexp + 15);
                res[14:0] = {hexp, frac[22:13]};
            end
        end else if (uexp >= -25) begin
            // subnormal half, a carry may form the smallest normal
            mag = {2'b01, v[22:0]} >> (-14 - uexp);
            mag = (mag + 25'h1000) >> 13;
            res[14:0] = mag[14:0];
        end
        return {16'd0, res};
    endfunction

    // half to single: exact, nan made quiet with payload kept
    function automatic logic [31:0] half_to_single(logic [15:0] h);
        logic [4:0]  hexp;
        logic [10:0] frac;
        logic [31:0] res;
        int          shift;
        hexp = h[14:10];
        frac = {1'b0, h[9:0]};
        res  = {h[15], 31'd0};
        shift = 0;
        if (hexp == 5'h1F) begin
            res = res | SGL_INF;
            if (frac != 0) res = res | SGL_QUIET | (32'(frac[9:0]) << 13);
        end else if (hexp == 0) begin
            if (frac != 0) begin
                while (!frac[10] && shift < 10) begin
                    frac = frac << 1;
                    shift++;
                end
                res[30:23] = 8'(113 - shift);
                res[22:13] = frac[9:0];
            end
        end else begin
            res[30:23] = 8'(hexp) + 8'd112;
            res[22:13] = frac[9:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %08h expected %08h", what, got, want);
        error_count++;
    endtask

    // sends one transaction and records its expected conversion
    task automatic send_value(t_kind kind, logic [31:0] value);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        converted_q.push_back(kind == KIND_S2H ? single_to_half(value)
                                               : half_to_single(value[15:0]));
    endtask

    task automatic release_bus();
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver stall pattern, redrawn each cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (converted_q.size() == 0) report_mismatch("unexpected", m_axis_tdata, 32'd0);
            else begin
                logic [31:0] want;
                want = converted_q.pop_front();
                if (m_axis_tdata !== want) report_mismatch("converted", m_axis_tdata, want);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[single_half_float_convert] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        release_bus();
        while (converted_q.size() != 0) @(posedge i_clk);
    endtask

    // corner patterns of both directions
    task automatic test_directed();
        send_value(KIND_S2H, 32'h0000_0000);   // zero
        send_value(KIND_S2H, 32'h8000_0001);   // negative subnormal
        send_value(KIND_S2H, 32'h7F80_0000);   // infinity
        send_value(KIND_S2H, 32'hFFC0_0001);   // nan
        send_value(KIND_S2H, 32'h4780_0000);   // finite overflow
        send_value(KIND_S2H, 32'h477F_F000);   // rounds into infinity
        send_value(KIND_S2H, 32'h3FFF_F000);   // mantissa carry into exponent
        send_value(KIND_S2H, 32'h3F80_0000);   // one
        send_value(KIND_S2H, 32'h3880_0000);   // smallest half normal
        send_value(KIND_S2H, 32'h387F_F000);   // subnormal rounding into normal
        send_value(KIND_S2H, 32'h38FF_F000);   // subnormal path rounding past the first binade
        send_value(KIND_S2H, 32'h3300_0000);   // half the smallest subnormal
        send_value(KIND_S2H, 32'h32FF_FFFF);   // just below, flushed
        send_value(KIND_S2H, 32'hFFFF_FFFF);
        send_value(KIND_H2S, 32'hFFFF_0000);   // upper bits ignored, zero
        send_value(KIND_H2S, 32'h0000_8000);   // negative zero
        send_value(KIND_H2S, 32'h0000_0001);   // smallest subnormal
        send_value(KIND_H2S, 32'h0000_03FF);   // largest subnormal
        send_value(KIND_H2S, 32'h0000_7C00);   // infinity
        send_value(KIND_H2S, 32'h0000_FC01);   // nan payload
        send_value(KIND_H2S, 32'h0000_7BFF);   // largest normal
        send_value(KIND_H2S, 32'hAAAA_3C00);   // one
    endtask

    // random patterns, exponents biased toward the interesting range
    task automatic test_random(int count);
        logic [31:0] value;
        repeat (count) begin
            value = $urandom();
            if ($urandom_range(3, 0) != 0) value[30:23] = 8'($urandom_range(150, 100));
            if ($urandom_range(15, 0) == 0) value[30:23] = {8{value[0]}};
            if ($urandom_range(1, 0)) send_value(KIND_S2H, value);
            else send_value(KIND_H2S, value);
        end
    endtask

    initial begin
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 23;
        recv_idle_pct = 54;
        test_directed();
        wait_drained();   // sender holds off until every result is back
        test_random(500);
        send_idle_pct = 54;
        recv_idle_pct = 23;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) $display("[single_half_float_convert] OK");
        else $display("[single_half_float_convert] ERROR");
        $finish;
    end

endmodule
